### sv/depth_preferred_hash_table_assert.svh
// assertion macros for depth_preferred_hash_table.sv
`ifndef DEPTH_PREFERRED_HASH_TABLE_ASSERT_SVH
`define DEPTH_PREFERRED_HASH_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked on every clock edge outside reset
`define DPHT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define DPHT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define DPHT_ASSERT(label, prop, msg)
`define DPHT_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

### sv/dpht_pkg.sv
`timescale 1ns / 1ps

package dpht_pkg;

    localparam int DEF_TABLE_ENTRIES = 16384;

    localparam int KEY_W    = 64;
    localparam int SCORE_W  = 16;
    localparam int DEPTH_W  = 8;
    localparam int MOVE_W   = 16;
    localparam int BOUND_W  = 2;
    localparam int TOTAL_W  = 15;
    localparam int ENTRY_W  = 47;

    localparam int SH_DEPTH = 16;
    localparam int SH_MOVE  = 24;
    localparam int SH_BOUND = 40;
    localparam int SH_VALID = 46;

    localparam int TOTAL_MAX = 32767;

    // key bytes folded into the slot residue
    localparam int KEY_BYTES = KEY_W / 8;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 64;

    typedef enum logic [1:0] {
        OP_GET   = 2'd0,
        OP_STORE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_COUNT = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_RESP
    } state_t;

    function automatic logic [ENTRY_W-1:0] pack_entry(
        input logic [SCORE_W-1:0] score,
        input logic [DEPTH_W-1:0] depth,
        input logic [MOVE_W-1:0]  move,
        input logic [BOUND_W-1:0] bound,
        input logic               valid
    );
        logic [ENTRY_W-1:0] e;
        e = '0;
        e[SH_DEPTH-1:0]             = score;
        e[SH_MOVE-1:SH_DEPTH]       = depth;
        e[SH_BOUND-1:SH_MOVE]       = move;
        e[SH_BOUND+BOUND_W-1:SH_BOUND] = bound;
        e[SH_VALID]                 = valid;
        return e;
    endfunction

endpackage

### sv/depth_preferred_hash_table.sv
`timescale 1ns / 1ps

// Direct-mapped transposition table with depth-preferred replacement, held in one
// registered-read RAM of TABLE_ENTRIES x 47 bits. The slot is position_key modulo
// TABLE_ENTRIES; no key tag is kept. One transaction is worked on at a time. A get or
// store runs slot select, RAM read, then read-modify-write and result before the next
// acceptance. When TABLE_ENTRIES is not a power of two, slot select runs the modulo in
// steps: the byte residues of the key are summed one key half per cycle, followed by a
// reciprocal multiply, a multiply-subtract and one final correction. A count goes
// straight from acceptance to its result. A clear sweeps the RAM one slot per cycle.
// After reset the same sweep runs with s_axis_tready low. The result waits in an
// output register, so a stalled master side holds the block only when the next result
// is ready. valid_total saturates at 32767.

`include "depth_preferred_hash_table_assert.svh"

module depth_preferred_hash_table #(
    parameter int TABLE_ENTRIES = dpht_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // position_key, new_score, new_depth, new_move, new_bound, new_valid, zero fill
    input  logic [dpht_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // operation
    input  logic [1:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // slot_valid, slot_score, slot_depth, slot_move, slot_bound, was_written,
    // valid_total, zero fill
    output logic [dpht_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    import dpht_pkg::*;

    localparam int  IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int  CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int  SAT_W   = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
    localparam bit  IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
    localparam int  ACC_W   = IDX_W + 11;
    localparam int  RCP_W   = 12;
    localparam int  PROD_W  = ACC_W + RCP_W;
    localparam int  STEP_W  = 3;
    localparam logic [IDX_W:0]   N_EXT    = (IDX_W + 1)'(TABLE_ENTRIES);
    localparam logic [ACC_W-1:0] N_ACC    = ACC_W'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // residue of each key byte weight modulo the table size
    function automatic logic [KEY_BYTES*IDX_W-1:0] byte_residues();
        logic [KEY_BYTES*IDX_W-1:0] r;
        logic [KEY_W-1:0]           p;
        r = '0;
        p = KEY_W'(1);
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            r[i*IDX_W +: IDX_W] = IDX_W'(p);
            p = (p << 8) % KEY_W'(TABLE_ENTRIES);
        end
        return r;
    endfunction

    localparam logic [KEY_BYTES*IDX_W-1:0] BYTE_RES = byte_residues();
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'((KEY_W'(1) << ACC_W) / KEY_W'(TABLE_ENTRIES));

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [RCP_W-1:0]      quo_reg, quo_next;
    logic [IDX_W:0]        rem_reg, rem_next;
    logic [IDX_W-1:0]      clr_idx_reg, clr_idx_next;
    logic                  clr_resp_reg, clr_resp_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SCORE_W-1:0]    nscore_reg, nscore_next;
    logic [DEPTH_W-1:0]    ndepth_reg, ndepth_next;
    logic [MOVE_W-1:0]     nmove_reg, nmove_next;
    logic [BOUND_W-1:0]    nbound_reg, nbound_next;
    logic                  nvalid_reg, nvalid_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic                  ram_re;
    logic [ENTRY_W-1:0]    ram_rdata;

    logic                  in_fire;
    logic                  out_free;
    logic                  out_load;

    // modulo by a table size that is not a power of two: residue sum, then the
    // quotient estimate from the reciprocal is at most one short
    logic [ACC_W-1:0]      mod_part;
    logic [PROD_W-1:0]     mod_prod;
    logic [ACC_W-1:0]      mod_diff;
    logic [IDX_W-1:0]      mod_fix;

    always_comb
    begin
        logic [KEY_W/2-1:0] half_key;
        logic [IDX_W-1:0]   res;
        half_key = (step_reg == '0) ? key_reg[KEY_W/2-1:0] : key_reg[KEY_W-1:KEY_W/2];
        mod_part = '0;
        for (int i = 0; i < KEY_BYTES / 2; i++)
        begin
            res = (step_reg == '0) ? BYTE_RES[i*IDX_W +: IDX_W]
                                   : BYTE_RES[(i + KEY_BYTES/2)*IDX_W +: IDX_W];
            mod_part = mod_part + ACC_W'(half_key[8*i +: 8]) * ACC_W'(res);
        end
    end

    assign mod_prod = PROD_W'(acc_reg) * PROD_W'(RECIP);
    assign mod_diff = acc_reg - ACC_W'(quo_reg) * N_ACC;
    assign mod_fix  = (rem_reg >= N_EXT) ? IDX_W'(rem_reg - N_EXT) : rem_reg[IDX_W-1:0];

    // read-modify-write view of the addressed slot
    logic                  old_valid;
    logic [DEPTH_W-1:0]    old_depth;
    logic                  do_write;
    logic [CNT_W-1:0]      cnt_upd;
    logic [SAT_W-1:0]      cnt_wide;
    logic [TOTAL_W-1:0]    total;
    logic [ENTRY_W-1:0]    shown;

    assign old_valid = ram_rdata[SH_VALID];
    assign old_depth = ram_rdata[SH_MOVE-1:SH_DEPTH];
    assign do_write  = (op_reg == OP_STORE) && (!old_valid || ndepth_reg >= old_depth);
    assign cnt_upd   = do_write ? cnt_reg + CNT_W'(nvalid_reg) - CNT_W'(old_valid) : cnt_reg;
    assign cnt_wide  = SAT_W'(cnt_upd);
    assign total     = (cnt_wide > SAT_W'(TOTAL_MAX)) ? TOTAL_W'(TOTAL_MAX)
                                                      : cnt_wide[TOTAL_W-1:0];
    assign shown     = (op_reg == OP_GET || op_reg == OP_STORE) ? ram_rdata : '0;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        slot_next      = slot_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        clr_idx_next   = clr_idx_reg;
        clr_resp_next  = clr_resp_reg;
        cnt_next       = cnt_reg;
        nscore_next    = nscore_reg;
        ndepth_next    = ndepth_reg;
        nmove_next     = nmove_reg;
        nbound_next    = nbound_reg;
        nvalid_next    = nvalid_reg;
        out_data_next  = out_data_reg;
        s_axis_tready  = 1'b0;
        out_load       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = slot_reg;
        ram_wdata      = pack_entry(nscore_reg, ndepth_reg, nmove_reg, nbound_reg, nvalid_reg);
        ram_re         = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                ram_wdata = '0;
                cnt_next  = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = clr_resp_reg ? S_RESP : S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    op_next     = op_t'(s_axis_tuser);
                    key_next    = s_axis_tdata[KEY_W-1:0];
                    nscore_next = s_axis_tdata[KEY_W+SCORE_W-1:KEY_W];
                    ndepth_next = s_axis_tdata[KEY_W+SCORE_W+DEPTH_W-1:KEY_W+SCORE_W];
                    nmove_next  = s_axis_tdata[KEY_W+SCORE_W+DEPTH_W+MOVE_W-1:
                                               KEY_W+SCORE_W+DEPTH_W];
                    nbound_next = s_axis_tdata[KEY_W+SCORE_W+DEPTH_W+MOVE_W+BOUND_W-1:
                                               KEY_W+SCORE_W+DEPTH_W+MOVE_W];
                    nvalid_next = s_axis_tdata[KEY_W+SCORE_W+DEPTH_W+MOVE_W+BOUND_W];
                    case (op_t'(s_axis_tuser))
                        OP_CLEAR:
                        begin
                            clr_idx_next  = '0;
                            clr_resp_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        OP_COUNT:
                        begin
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            if (IS_POW2)
                            begin
                                slot_next  = s_axis_tdata[IDX_W-1:0];
                                state_next = S_READ;
                            end
                            else
                            begin
                                step_next  = '0;
                                state_next = S_MOD;
                            end
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    STEP_W'(0):
                    begin
                        acc_next = mod_part;
                    end
                    STEP_W'(1):
                    begin
                        acc_next = acc_reg + mod_part;
                    end
                    STEP_W'(2):
                    begin
                        quo_next = mod_prod[PROD_W-1:ACC_W];
                    end
                    STEP_W'(3):
                    begin
                        rem_next = mod_diff[IDX_W:0];
                    end
                    default:
                    begin
                        slot_next  = mod_fix;
                        state_next = S_READ;
                    end
                endcase
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    ram_we    = do_write;
                    cnt_next  = cnt_upd;
                    out_data_next = {5'b0, total, do_write,
                                     shown[SH_BOUND+BOUND_W-1:SH_BOUND],
                                     shown[SH_BOUND-1:SH_MOVE],
                                     shown[SH_MOVE-1:SH_DEPTH],
                                     shown[SH_DEPTH-1:0],
                                     shown[SH_VALID]};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            clr_resp_reg  <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            op_reg        <= OP_GET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            clr_resp_reg  <= clr_resp_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            op_reg        <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        slot_reg     <= slot_next;
        acc_reg      <= acc_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        nscore_reg   <= nscore_next;
        ndepth_reg   <= ndepth_next;
        nmove_reg    <= nmove_next;
        nbound_reg   <= nbound_next;
        nvalid_reg   <= nvalid_next;
        out_data_reg <= out_data_next;
    end

    dpht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `DPHT_ASSERT(a_cnt_bound, cnt_reg <= CNT_W'(TABLE_ENTRIES),
        "valid counter exceeds table size")
    `DPHT_ASSERT(a_we_state, ram_we |-> (state_reg == S_CLEAR || state_reg == S_RESP),
        "table written outside clear sweep or update")
    `DPHT_ASSERT(a_one_at_a_time, in_fire |=> !s_axis_tready,
        "second transaction accepted while one is in progress")
    `DPHT_ASSERT(a_clear_count, (state_reg == S_CLEAR) |=> (cnt_reg == '0),
        "valid counter not zero during clear sweep")

endmodule

### sv/dpht_ram.sv
`timescale 1ns / 1ps

module dpht_ram #(
    parameter int WIDTH = 47,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds until the next read
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### dv/depth_preferred_hash_table_checker.sv
`timescale 1ns / 1ps

module depth_preferred_hash_table_checker #(
    parameter int TABLE_ENTRIES = dpht_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [dpht_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [1:0]                      s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [dpht_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output int                              mismatch_count,
    output int                              pending_count
);

    import dpht_pkg::*;

    // request field offsets in s_axis_tdata
    localparam int RQ_SCORE = KEY_W;
    localparam int RQ_DEPTH = RQ_SCORE + SCORE_W;
    localparam int RQ_MOVE  = RQ_DEPTH + DEPTH_W;
    localparam int RQ_BOUND = RQ_MOVE + MOVE_W;
    localparam int RQ_VALID = RQ_BOUND + BOUND_W;

    // response field offsets in m_axis_tdata
    localparam int RS_SCORE = 1;
    localparam int RS_DEPTH = RS_SCORE + SCORE_W;
    localparam int RS_MOVE  = RS_DEPTH + DEPTH_W;
    localparam int RS_BOUND = RS_MOVE + MOVE_W;
    localparam int RS_WROTE = RS_BOUND + BOUND_W;
    localparam int RS_TOTAL = RS_WROTE + 1;

    typedef struct packed {
        logic               valid;
        logic [BOUND_W-1:0] bound;
        logic [MOVE_W-1:0]  move;
        logic [DEPTH_W-1:0] depth;
        logic [SCORE_W-1:0] score;
    } tt_entry_t;

    typedef struct packed {
        logic               slot_valid;
        logic [SCORE_W-1:0] slot_score;
        logic [DEPTH_W-1:0] slot_depth;
        logic [MOVE_W-1:0]  slot_move;
        logic [BOUND_W-1:0] slot_bound;
        logic               was_written;
        logic [TOTAL_W-1:0] valid_total;
    } probe_result_t;

    tt_entry_t     shadow_table [TABLE_ENTRIES];
    int            live_slots;
    probe_result_t expected_probes [$];

    initial
    begin
        mismatch_count = 0;
        pending_count  = 0;
    end

    // updates the shadow table and returns the response the block owes
    function automatic probe_result_t predict_probe(input op_t op,
                                                    input logic [IN_DATA_W-1:0] req);
        tt_entry_t     cur;
        tt_entry_t     offered;
        probe_result_t res;
        int            slot;
        logic          replace;
        slot          = int'(req[KEY_W-1:0] % 64'(TABLE_ENTRIES));
        cur           = shadow_table[slot];
        offered.score = req[RQ_SCORE +: SCORE_W];
        offered.depth = req[RQ_DEPTH +: DEPTH_W];
        offered.move  = req[RQ_MOVE +: MOVE_W];
        offered.bound = req[RQ_BOUND +: BOUND_W];
        offered.valid = req[RQ_VALID];
        res           = '0;
        replace       = 1'b0;
        case (op)
            OP_STORE:
            begin
                replace = !cur.valid || (offered.depth >= cur.depth);
                if (replace)
                begin
                    shadow_table[slot] = offered;
                    live_slots += int'(offered.valid) - int'(cur.valid);
                end
            end
            OP_CLEAR:
            begin
                foreach (shadow_table[i])
                    shadow_table[i] = '0;
                live_slots = 0;
            end
            default:
            begin
            end
        endcase
        if (op == OP_GET || op == OP_STORE)
        begin
            res.slot_valid = cur.valid;
            res.slot_score = cur.score;
            res.slot_depth = cur.depth;
            res.slot_move  = cur.move;
            res.slot_bound = cur.bound;
        end
        res.was_written = replace;
        res.valid_total = TOTAL_W'(live_slots > TOTAL_MAX ? TOTAL_MAX : live_slots);
        return res;
    endfunction

    task automatic compare_field(input string field, input int want, input int seen);
        if (want != seen)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, field,
                         want, seen);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        probe_result_t want;
        if (!rst_n)
        begin
            foreach (shadow_table[i])
                shadow_table[i] = '0;
            live_slots = 0;
            expected_probes.delete();
            pending_count = 0;
        end
        else
        begin
            // response first: it always belongs to an earlier request
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_probes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: response with no request outstanding, tdata 0x%h",
                                 $realtime, m_axis_tdata);
                end
                else
                begin
                    want = expected_probes.pop_front();
                    compare_field("slot_valid", want.slot_valid, m_axis_tdata[0]);
                    compare_field("slot_score", want.slot_score,
                                  m_axis_tdata[RS_SCORE +: SCORE_W]);
                    compare_field("slot_depth", want.slot_depth,
                                  m_axis_tdata[RS_DEPTH +: DEPTH_W]);
                    compare_field("slot_move", want.slot_move,
                                  m_axis_tdata[RS_MOVE +: MOVE_W]);
                    compare_field("slot_bound", want.slot_bound,
                                  m_axis_tdata[RS_BOUND +: BOUND_W]);
                    compare_field("was_written", want.was_written, m_axis_tdata[RS_WROTE]);
                    compare_field("valid_total", want.valid_total,
                                  m_axis_tdata[RS_TOTAL +: TOTAL_W]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_probes.push_back(predict_probe(op_t'(s_axis_tuser), s_axis_tdata));
            pending_count = expected_probes.size();
        end
    end

endmodule

### dv/depth_preferred_hash_table_tb.sv
`timescale 1ns / 1ps

module depth_preferred_hash_table_tb;

    import dpht_pkg::*;

    localparam int SLOT_BITS    = $clog2(DEF_TABLE_ENTRIES);
    localparam int RANDOM_ITEMS = 400;
    localparam int HOT_SLOTS    = 24;
    // a clear sweeps the whole table, so this covers it plus a long receiver stall
    localparam int IDLE_LIMIT   = 4 * DEF_TABLE_ENTRIES + 2000;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = OP_GET;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int mismatch_count;
    int pending_count;
    int burst_left  = 0;
    int stall_mode  = 0;
    int stall_left  = 0;
    int idle_cycles = 0;

    logic [SLOT_BITS-1:0] hot_slots [HOT_SLOTS];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    depth_preferred_hash_table #(
        .TABLE_ENTRIES(DEF_TABLE_ENTRIES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    depth_preferred_hash_table_checker #(
        .TABLE_ENTRIES(DEF_TABLE_ENTRIES)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatch_count(mismatch_count),
        .pending_count (pending_count)
    );

    // receiver alternates between always ready, half ready and mostly stalled
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(32, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // one transaction on the request side, sent in bursts with idle gaps between
    task automatic issue_request(input op_t op, input logic [KEY_W-1:0] key,
                                 input logic [SCORE_W-1:0] score,
                                 input logic [DEPTH_W-1:0] depth,
                                 input logic [MOVE_W-1:0] move,
                                 input logic [BOUND_W-1:0] bound, input logic valid);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_DATA_W - 107){1'b0}}, valid, bound, move, depth, score, key};
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
    endtask

    initial
    begin
        logic [KEY_W-1:0]   key;
        logic [DEPTH_W-1:0] depth;
        op_t                op;
        int                 pick;
        int                 clears_left;
        clears_left = 4;
        hot_slots[0] = '0;
        hot_slots[1] = '1;
        for (int i = 2; i < HOT_SLOTS; i++)
            hot_slots[i] = SLOT_BITS'($urandom);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // empty slot, then store and read back through an aliasing key
        issue_request(OP_GET, 64'h0, 16'h0, 8'd0, 16'h0, 2'd0, 1'b0);
        issue_request(OP_STORE, 64'h0, 16'h8000, 8'd5, 16'hFFFF, 2'd3, 1'b1);
        issue_request(OP_GET, 64'h4000, 16'h0, 8'd0, 16'h0, 2'd0, 1'b0);
        // shallower store is refused, equal depth replaces
        issue_request(OP_STORE, 64'h4000, 16'h1111, 8'd4, 16'h2222, 2'd2, 1'b1);
        issue_request(OP_STORE, 64'h8000_0000_0000_4000, 16'h7FFF, 8'd5, 16'h1234, 2'd1, 1'b1);
        issue_request(OP_STORE, '1, 16'h7FFF, 8'd255, 16'h0, 2'd0, 1'b1);
        // an invalid entry is written and then overwritten regardless of its depth
        issue_request(OP_STORE, 64'h1, 16'hABCD, 8'd255, 16'h5555, 2'd2, 1'b0);
        issue_request(OP_STORE, 64'h1, 16'h0001, 8'd0, 16'hAAAA, 2'd1, 1'b1);
        // storing an invalid entry over a valid one lowers the count
        issue_request(OP_STORE, 64'h0, 16'h0, 8'd255, 16'h0, 2'd0, 1'b0);
        issue_request(OP_GET, 64'h0, 16'h0, 8'd0, 16'h0, 2'd0, 1'b0);
        issue_request(OP_COUNT, '1, '1, '1, '1, '1, 1'b1);
        issue_request(OP_CLEAR, 64'h0, 16'h0, 8'd0, 16'h0, 2'd0, 1'b0);
        issue_request(OP_GET, '1, 16'h0, 8'd0, 16'h0, 2'd0, 1'b0);
        issue_request(OP_COUNT, 64'h0, 16'h0, 8'd0, 16'h0, 2'd0, 1'b0);
        issue_request(OP_STORE, '1, 16'h8001, 8'd0, 16'h8000, 2'd3, 1'b1);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            key  = {$urandom, $urandom};
            // most traffic lands on a few slots so replacement decisions get exercised
            if ($urandom_range(0, 4) != 0)
                key[SLOT_BITS-1:0] = hot_slots[$urandom_range(0, HOT_SLOTS - 1)];
            depth = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
            if (pick == 0 && clears_left > 0)
            begin
                op = OP_CLEAR;
                clears_left--;
            end
            else if (pick < 50)
                op = OP_STORE;
            else if (pick < 88)
                op = OP_GET;
            else
                op = OP_COUNT;
            issue_request(op, key, 16'($urandom), depth, 16'($urandom), 2'($urandom),
                          $urandom_range(0, 6) != 0);
        end
        s_axis_tvalid <= 1'b0;
        @(posedge clk);

        while (pending_count != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### depth_preferred_hash_table.f
+incdir+sv
sv/dpht_pkg.sv
sv/dpht_ram.sv
sv/depth_preferred_hash_table.sv
dv/depth_preferred_hash_table_checker.sv
dv/depth_preferred_hash_table_tb.sv
